>>> rtl/i2cdw_pkg.sv
// shared types and constants for the i2c display write master
package i2cdw_pkg;

    localparam int unsigned HALF_W    = 16;
    localparam int unsigned TIMEOUT_W = 10;
    localparam int unsigned ADDR_W    = 8;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CFG_W     = 16;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [HALF_W-1:0]    HALF_RESET    = 16'd2;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 10'd250;
    localparam logic [ADDR_W-1:0]    ADDR_RESET    = 8'h78;

    localparam logic [BYTE_W-1:0] CTRL_CMD  = 8'h00;
    localparam logic [BYTE_W-1:0] CTRL_DATA = 8'h40;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HALF_PERIOD = 2'd0,
        CFG_ACK_TIMEOUT = 2'd1,
        CFG_DEV_ADDR    = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_START_A  = 4'd1,
        PH_START_B  = 4'd2,
        PH_START_C  = 4'd3,
        PH_BIT_LOW  = 4'd4,
        PH_BIT_HIGH = 4'd5,
        PH_ACK_PREP = 4'd6,
        PH_ACK_HIGH = 4'd7,
        PH_ACK_LOW  = 4'd8,
        PH_STOP_A   = 4'd9,
        PH_STOP_B   = 4'd10,
        PH_STOP_C   = 4'd11
    } phase_t;

    typedef struct packed {
        logic [HALF_W-1:0]    half_period;
        logic [TIMEOUT_W-1:0] ack_timeout;
        logic [ADDR_W-1:0]    dev_addr;
    } cfg_t;

    typedef struct packed {
        logic scl;
        logic sda;
        logic sda_en;
        logic busy;
        logic took;
        logic done;
        logic err;
    } res_t;

endpackage

>>> rtl/i2cdw_seq.sv
// bus sequencer: phase state, bit and byte counters, hold and poll timers
module i2cdw_seq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic                  action,
    input  logic                  is_data,
    input  logic [i2cdw_pkg::BYTE_W-1:0] value,
    input  logic                  sda_sample,
    input  i2cdw_pkg::cfg_t       cfg,
    output i2cdw_pkg::res_t       res
);

    i2cdw_pkg::phase_t phase_reg, phase_next;
    logic [2:0]                         bit_reg, bit_next;
    logic [1:0]                         slot_reg, slot_next;
    logic [i2cdw_pkg::BYTE_W-1:0]       shift_reg, shift_next;
    logic [i2cdw_pkg::BYTE_W-1:0]       pend_val_reg, pend_val_next;
    logic                               pend_kind_reg, pend_kind_next;
    logic [i2cdw_pkg::HALF_W-1:0]       hold_reg, hold_next;
    logic [i2cdw_pkg::TIMEOUT_W-1:0]    poll_reg, poll_next;
    logic                               err_reg, err_next;

    logic [i2cdw_pkg::HALF_W:0]         hold_inc;
    logic [i2cdw_pkg::HALF_W:0]         hp;
    logic                               took, done, err_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= i2cdw_pkg::PH_IDLE;
            bit_reg       <= '0;
            slot_reg      <= '0;
            shift_reg     <= '0;
            pend_val_reg  <= '0;
            pend_kind_reg <= 1'b0;
            hold_reg      <= '0;
            poll_reg      <= '0;
            err_reg       <= 1'b0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            bit_reg       <= bit_next;
            slot_reg      <= slot_next;
            shift_reg     <= shift_next;
            pend_val_reg  <= pend_val_next;
            pend_kind_reg <= pend_kind_next;
            hold_reg      <= hold_next;
            poll_reg      <= poll_next;
            err_reg       <= err_next;
        end
    end

    // zero half period behaves as one tick
    assign hp       = (cfg.half_period == '0) ? 17'd1 : {1'b0, cfg.half_period};
    assign hold_inc = {1'b0, hold_reg} + 17'd1;

    always_comb
    begin
        phase_next     = phase_reg;
        bit_next       = bit_reg;
        slot_next      = slot_reg;
        shift_next     = shift_reg;
        pend_val_next  = pend_val_reg;
        pend_kind_next = pend_kind_reg;
        hold_next      = hold_reg;
        poll_next      = poll_reg;
        err_next       = err_reg;
        took           = 1'b0;
        done           = 1'b0;
        err_out        = 1'b0;

        if (action)
        begin
            if (phase_reg == i2cdw_pkg::PH_IDLE)
            begin
                took           = 1'b1;
                pend_val_next  = value;
                pend_kind_next = is_data;
                shift_next     = cfg.dev_addr;
                slot_next      = '0;
                bit_next       = '0;
                hold_next      = '0;
                poll_next      = '0;
                err_next       = 1'b0;
                phase_next     = i2cdw_pkg::PH_START_A;
            end
        end
        else if (phase_reg != i2cdw_pkg::PH_IDLE)
        begin
            if (hold_inc < hp)
            begin
                hold_next = hold_inc[i2cdw_pkg::HALF_W-1:0];
            end
            else if (phase_reg == i2cdw_pkg::PH_ACK_HIGH)
            begin
                // acknowledge polling once the high half phase has elapsed
                if (!sda_sample)
                begin
                    hold_next  = '0;
                    phase_next = i2cdw_pkg::PH_ACK_LOW;
                end
                else if (poll_reg >= cfg.ack_timeout)
                begin
                    hold_next  = '0;
                    err_next   = 1'b1;
                    phase_next = i2cdw_pkg::PH_STOP_A;
                end
                else
                begin
                    poll_next = poll_reg + 10'd1;
                end
            end
            else
            begin
                hold_next = '0;
                unique case (phase_reg)
                    i2cdw_pkg::PH_START_A: phase_next = i2cdw_pkg::PH_START_B;
                    i2cdw_pkg::PH_START_B: phase_next = i2cdw_pkg::PH_START_C;
                    i2cdw_pkg::PH_START_C:
                    begin
                        phase_next = i2cdw_pkg::PH_BIT_LOW;
                        bit_next   = '0;
                    end
                    i2cdw_pkg::PH_BIT_LOW: phase_next = i2cdw_pkg::PH_BIT_HIGH;
                    i2cdw_pkg::PH_BIT_HIGH:
                    begin
                        if (bit_reg == 3'd7)
                        begin
                            phase_next = i2cdw_pkg::PH_ACK_PREP;
                        end
                        else
                        begin
                            bit_next   = bit_reg + 3'd1;
                            shift_next = {shift_reg[i2cdw_pkg::BYTE_W-2:0], 1'b0};
                            phase_next = i2cdw_pkg::PH_BIT_LOW;
                        end
                    end
                    i2cdw_pkg::PH_ACK_PREP:
                    begin
                        phase_next = i2cdw_pkg::PH_ACK_HIGH;
                        poll_next  = '0;
                    end
                    i2cdw_pkg::PH_ACK_LOW:
                    begin
                        if (slot_reg >= 2'd2)
                        begin
                            phase_next = i2cdw_pkg::PH_STOP_A;
                        end
                        else
                        begin
                            // address done: control byte next, then the value
                            slot_next  = slot_reg + 2'd1;
                            shift_next = (slot_reg == 2'd0)
                                ? (pend_kind_reg ? i2cdw_pkg::CTRL_DATA : i2cdw_pkg::CTRL_CMD)
                                : pend_val_reg;
                            bit_next   = '0;
                            phase_next = i2cdw_pkg::PH_BIT_LOW;
                        end
                    end
                    i2cdw_pkg::PH_STOP_A: phase_next = i2cdw_pkg::PH_STOP_B;
                    i2cdw_pkg::PH_STOP_B: phase_next = i2cdw_pkg::PH_STOP_C;
                    i2cdw_pkg::PH_STOP_C:
                    begin
                        phase_next = i2cdw_pkg::PH_IDLE;
                        done       = 1'b1;
                        err_out    = err_reg;
                    end
                    default: phase_next = phase_reg;
                endcase
            end
        end
    end

    // line levels follow the phase being entered
    always_comb
    begin
        res.scl    = 1'b1;
        res.sda    = 1'b1;
        unique case (phase_next)
            i2cdw_pkg::PH_START_B:  begin res.scl = 1'b1; res.sda = 1'b0;          end
            i2cdw_pkg::PH_START_C:  begin res.scl = 1'b0; res.sda = 1'b0;          end
            i2cdw_pkg::PH_BIT_LOW:  begin res.scl = 1'b0; res.sda = shift_next[7]; end
            i2cdw_pkg::PH_BIT_HIGH: begin res.scl = 1'b1; res.sda = shift_next[7]; end
            i2cdw_pkg::PH_ACK_PREP: begin res.scl = 1'b0; res.sda = 1'b1;          end
            i2cdw_pkg::PH_ACK_HIGH: begin res.scl = 1'b1; res.sda = 1'b1;          end
            i2cdw_pkg::PH_ACK_LOW:  begin res.scl = 1'b0; res.sda = 1'b1;          end
            i2cdw_pkg::PH_STOP_A:   begin res.scl = 1'b0; res.sda = 1'b0;          end
            i2cdw_pkg::PH_STOP_B:   begin res.scl = 1'b1; res.sda = 1'b0;          end
            default:                begin res.scl = 1'b1; res.sda = 1'b1;          end
        endcase
        res.sda_en = !((phase_next == i2cdw_pkg::PH_ACK_PREP) ||
                       (phase_next == i2cdw_pkg::PH_ACK_HIGH) ||
                       (phase_next == i2cdw_pkg::PH_ACK_LOW));
        res.busy   = (phase_next != i2cdw_pkg::PH_IDLE);
        res.took   = took;
        res.done   = done;
        res.err    = err_out;
    end

endmodule

>>> rtl/i2c_display_write_master_unit.sv
// top level of the i2c display write master: config registers, sequencer, result register
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------------
//  in      | sink      | in_valid / in_ready  | action, is_data, value, sda_sample
//  out     | source    | out_valid / out_ready| scl_level, sda_level, sda_enable, busy_res,
//          |           |                      | accepted, done_res, ack_error
//  cfg     | sink      | cfg_we (no wait)     | cfg_index, cfg_wdata
//
// one transaction per cycle while in_ready is high; the result is registered and shows in the cycle after acceptance
// in_ready is low only while a held result is not taken (out_valid high, out_ready low)
// reset puts the sequencer idle and loads the register defaults; the result register is not reset
module i2c_display_write_master_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              action,
    input  logic                              is_data,
    input  logic [i2cdw_pkg::BYTE_W-1:0]      value,
    input  logic                              sda_sample,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              scl_level,
    output logic                              sda_level,
    output logic                              sda_enable,
    output logic                              busy_res,
    output logic                              accepted,
    output logic                              done_res,
    output logic                              ack_error,
    input  logic                              cfg_we,
    input  logic [i2cdw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [i2cdw_pkg::CFG_W-1:0]       cfg_wdata
);

    i2cdw_pkg::cfg_t cfg_reg;
    i2cdw_pkg::res_t res_next;
    i2cdw_pkg::res_t res_reg;
    logic            out_valid_reg;
    logic            step;

    assign in_ready = !out_valid_reg || out_ready;
    assign step     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_period <= i2cdw_pkg::HALF_RESET;
            cfg_reg.ack_timeout <= i2cdw_pkg::TIMEOUT_RESET;
            cfg_reg.dev_addr    <= i2cdw_pkg::ADDR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                i2cdw_pkg::CFG_HALF_PERIOD:
                    cfg_reg.half_period <= cfg_wdata[i2cdw_pkg::HALF_W-1:0];
                i2cdw_pkg::CFG_ACK_TIMEOUT:
                    cfg_reg.ack_timeout <= cfg_wdata[i2cdw_pkg::TIMEOUT_W-1:0];
                i2cdw_pkg::CFG_DEV_ADDR:
                    cfg_reg.dev_addr    <= cfg_wdata[i2cdw_pkg::ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    i2cdw_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .action     (action),
        .is_data    (is_data),
        .value      (value),
        .sda_sample (sda_sample),
        .cfg        (cfg_reg),
        .res        (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign scl_level  = res_reg.scl;
    assign sda_level  = res_reg.sda;
    assign sda_enable = res_reg.sda_en;
    assign busy_res   = res_reg.busy;
    assign accepted   = res_reg.took;
    assign done_res   = res_reg.done;
    assign ack_error  = res_reg.err;

endmodule

>>> rtl/i2cdw_checker.sv
// port-level checks for the i2c display write master, bound to the top level
module i2cdw_checker (
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_ready,
    input logic scl_level,
    input logic sda_level,
    input logic sda_enable,
    input logic busy_res,
    input logic accepted,
    input logic done_res,
    input logic ack_error
);

    // a held result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // error is only reported with the end of the stop condition
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ack_error |-> done_res)
        else $error("ack error without done");

    // a finished transaction leaves the bus idle with both lines high
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> !busy_res && scl_level && sda_level && sda_enable)
        else $error("done with bus not idle");

    // a taken request starts a transaction, lines still high at start
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && accepted |-> busy_res && !done_res && scl_level && sda_level)
        else $error("accepted request did not start a transaction");

    // released data line reads high
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !sda_enable |-> sda_level && busy_res)
        else $error("released sda not high");

endmodule

bind i2c_display_write_master_unit i2cdw_checker u_i2cdw_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .scl_level  (scl_level),
    .sda_level  (sda_level),
    .sda_enable (sda_enable),
    .busy_res   (busy_res),
    .accepted   (accepted),
    .done_res   (done_res),
    .ack_error  (ack_error)
);

>>> tb/tb_top.sv
// self-checking testbench for the i2c display write master: line-level prediction and checks
`timescale 1ns / 100ps

module tb_top;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic                         action;
        logic                         is_data;
        logic [i2cdw_pkg::BYTE_W-1:0] value;
        logic                         sda_sample;
    } bus_item_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    logic                            action = 1'b0;
    logic                            is_data = 1'b0;
    logic [i2cdw_pkg::BYTE_W-1:0]    value = '0;
    logic                            sda_sample = 1'b0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic                            scl_level;
    logic                            sda_level;
    logic                            sda_enable;
    logic                            busy_res;
    logic                            accepted;
    logic                            done_res;
    logic                            ack_error;
    logic                            cfg_we = 1'b0;
    logic [i2cdw_pkg::CFG_IDX_W-1:0] cfg_index = i2cdw_pkg::CFG_HALF_PERIOD;
    logic [i2cdw_pkg::CFG_W-1:0]     cfg_wdata = '0;

    i2c_display_write_master_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .is_data    (is_data),
        .value      (value),
        .sda_sample (sda_sample),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .scl_level  (scl_level),
        .sda_level  (sda_level),
        .sda_enable (sda_enable),
        .busy_res   (busy_res),
        .accepted   (accepted),
        .done_res   (done_res),
        .ack_error  (ack_error),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata)
    );

    // register copies used by the line predictor
    logic [i2cdw_pkg::HALF_W-1:0]    half_ticks = i2cdw_pkg::HALF_RESET;
    logic [i2cdw_pkg::TIMEOUT_W-1:0] ack_limit  = i2cdw_pkg::TIMEOUT_RESET;
    logic [i2cdw_pkg::ADDR_W-1:0]    dev_addr   = i2cdw_pkg::ADDR_RESET;

    // bus sequencer state of the predictor
    i2cdw_pkg::phase_t               bus_phase   = i2cdw_pkg::PH_IDLE;
    logic [2:0]                      bit_idx     = '0;
    logic [1:0]                      byte_idx    = '0;
    logic [i2cdw_pkg::BYTE_W-1:0]    tx_shift    = '0;
    logic [i2cdw_pkg::BYTE_W-1:0]    req_value   = '0;
    logic                            req_kind    = 1'b0;
    logic [i2cdw_pkg::HALF_W-1:0]    hold_ticks  = '0;
    logic [i2cdw_pkg::TIMEOUT_W-1:0] ack_polls   = '0;
    logic                            scl_q       = 1'b1;
    logic                            sda_q       = 1'b1;
    logic                            abort_flag  = 1'b0;

    bus_item_t        pending_items[$];
    i2cdw_pkg::res_t  expected_lines[$];
    bus_item_t        cur_item;

    bit allow_idling = 1'b1;
    int src_gap;
    int sink_gap;
    int fail_count;
    int cycle_count;
    int lines_checked;
    int writes_framed;
    int writes_aborted;
    int requests_refused;
    int settings_used;

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // advance the predicted bus sequencer by one accepted transaction
    task automatic predict_bus_lines(input bus_item_t it);
        int              half_eff;
        i2cdw_pkg::res_t r;
        logic            took;
        logic            fin;
        logic            fin_err;
        half_eff = (half_ticks == '0) ? 1 : int'(half_ticks);
        took = 1'b0;
        fin = 1'b0;
        fin_err = 1'b0;
        if (it.action)
        begin
            if (bus_phase == i2cdw_pkg::PH_IDLE)
            begin
                took = 1'b1;
                req_value = it.value;
                req_kind = it.is_data;
                tx_shift = dev_addr;
                byte_idx = '0;
                bit_idx = '0;
                hold_ticks = '0;
                ack_polls = '0;
                abort_flag = 1'b0;
                bus_phase = i2cdw_pkg::PH_START_A;
            end
            else
            begin
                requests_refused++;
            end
        end
        else if (bus_phase != i2cdw_pkg::PH_IDLE)
        begin
            if (int'(hold_ticks) + 1 < half_eff)
            begin
                hold_ticks = hold_ticks + 16'd1;
            end
            else if (bus_phase == i2cdw_pkg::PH_ACK_HIGH)
            begin
                if (!it.sda_sample)
                begin
                    hold_ticks = '0;
                    bus_phase = i2cdw_pkg::PH_ACK_LOW;
                end
                else if (ack_polls >= ack_limit)
                begin
                    hold_ticks = '0;
                    abort_flag = 1'b1;
                    bus_phase = i2cdw_pkg::PH_STOP_A;
                end
                else
                begin
                    ack_polls = ack_polls + 10'd1;
                end
            end
            else
            begin
                hold_ticks = '0;
                case (bus_phase)
                    i2cdw_pkg::PH_START_A: bus_phase = i2cdw_pkg::PH_START_B;
                    i2cdw_pkg::PH_START_B: bus_phase = i2cdw_pkg::PH_START_C;
                    i2cdw_pkg::PH_START_C:
                    begin
                        bus_phase = i2cdw_pkg::PH_BIT_LOW;
                        bit_idx = '0;
                    end
                    i2cdw_pkg::PH_BIT_LOW: bus_phase = i2cdw_pkg::PH_BIT_HIGH;
                    i2cdw_pkg::PH_BIT_HIGH:
                    begin
                        if (bit_idx == 3'd7)
                        begin
                            bus_phase = i2cdw_pkg::PH_ACK_PREP;
                        end
                        else
                        begin
                            bit_idx = bit_idx + 3'd1;
                            tx_shift = tx_shift << 1;
                            bus_phase = i2cdw_pkg::PH_BIT_LOW;
                        end
                    end
                    i2cdw_pkg::PH_ACK_PREP:
                    begin
                        bus_phase = i2cdw_pkg::PH_ACK_HIGH;
                        ack_polls = '0;
                    end
                    i2cdw_pkg::PH_ACK_LOW:
                    begin
                        if (byte_idx >= 2'd2)
                        begin
                            bus_phase = i2cdw_pkg::PH_STOP_A;
                        end
                        else
                        begin
                            byte_idx = byte_idx + 2'd1;
                            // control byte goes second, the payload byte third
                            if (byte_idx == 2'd1)
                                tx_shift = req_kind ? i2cdw_pkg::CTRL_DATA : i2cdw_pkg::CTRL_CMD;
                            else
                                tx_shift = req_value;
                            bit_idx = '0;
                            bus_phase = i2cdw_pkg::PH_BIT_LOW;
                        end
                    end
                    i2cdw_pkg::PH_STOP_A: bus_phase = i2cdw_pkg::PH_STOP_B;
                    i2cdw_pkg::PH_STOP_B: bus_phase = i2cdw_pkg::PH_STOP_C;
                    default:
                    begin
                        bus_phase = i2cdw_pkg::PH_IDLE;
                        fin = 1'b1;
                        fin_err = abort_flag;
                    end
                endcase
            end
        end

        case (bus_phase)
            i2cdw_pkg::PH_START_B:  {scl_q, sda_q} = 2'b10;
            i2cdw_pkg::PH_START_C:  {scl_q, sda_q} = 2'b00;
            i2cdw_pkg::PH_BIT_LOW:  {scl_q, sda_q} = {1'b0, tx_shift[7]};
            i2cdw_pkg::PH_BIT_HIGH: {scl_q, sda_q} = {1'b1, tx_shift[7]};
            i2cdw_pkg::PH_ACK_PREP: {scl_q, sda_q} = 2'b01;
            i2cdw_pkg::PH_ACK_HIGH: {scl_q, sda_q} = 2'b11;
            i2cdw_pkg::PH_ACK_LOW:  {scl_q, sda_q} = 2'b01;
            i2cdw_pkg::PH_STOP_A:   {scl_q, sda_q} = 2'b00;
            i2cdw_pkg::PH_STOP_B:   {scl_q, sda_q} = 2'b10;
            default:                {scl_q, sda_q} = 2'b11;
        endcase

        r.scl = scl_q;
        r.sda = sda_q;
        r.sda_en = !(bus_phase == i2cdw_pkg::PH_ACK_PREP ||
                     bus_phase == i2cdw_pkg::PH_ACK_HIGH ||
                     bus_phase == i2cdw_pkg::PH_ACK_LOW);
        r.busy = (bus_phase != i2cdw_pkg::PH_IDLE);
        r.took = took;
        r.done = fin;
        r.err = fin_err;
        expected_lines.push_back(r);
    endtask

    // driver: presents queued transactions, holds each until taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            src_gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_bus_lines(cur_item);
            if (!in_valid || in_ready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    in_valid <= 1'b0;
                end
                else if (allow_idling && $urandom_range(0, 5) == 0)
                begin
                    src_gap = $urandom_range(0, 3);
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    cur_item = pending_items.pop_front();
                    action <= cur_item.action;
                    is_data <= cur_item.is_data;
                    value <= cur_item.value;
                    sda_sample <= cur_item.sda_sample;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    function automatic void match_field(input string name, input logic want, input logic got);
        if (want !== got)
        begin
            $error("%s: expected %0b, got %0b", name, want, got);
            fail_count++;
        end
    endfunction

    // monitor: takes results with random back-pressure and checks them in order
    always @(posedge clk or negedge rst_n)
    begin
        i2cdw_pkg::res_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            sink_gap = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_lines.size() == 0)
                begin
                    $error("result with no transaction outstanding");
                    fail_count++;
                end
                else
                begin
                    want = expected_lines.pop_front();
                    match_field("scl_level", want.scl, scl_level);
                    match_field("sda_level", want.sda, sda_level);
                    match_field("sda_enable", want.sda_en, sda_enable);
                    match_field("busy_res", want.busy, busy_res);
                    match_field("accepted", want.took, accepted);
                    match_field("done_res", want.done, done_res);
                    match_field("ack_error", want.err, ack_error);
                    lines_checked++;
                    if (want.done) writes_framed++;
                    if (want.err) writes_aborted++;
                end
            end
            if (sink_gap > 0)
            begin
                sink_gap--;
                out_ready <= 1'b0;
            end
            else if (allow_idling && $urandom_range(0, 5) == 0)
            begin
                sink_gap = $urandom_range(0, 3);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic queue_item(input logic act, input logic kind,
                              input logic [i2cdw_pkg::BYTE_W-1:0] val, input logic samp);
        bus_item_t it;
        it.action = act;
        it.is_data = kind;
        it.value = val;
        it.sda_sample = samp;
        pending_items.push_back(it);
    endtask

    function automatic logic [i2cdw_pkg::BYTE_W-1:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // a write request followed by roughly one frame of ticks, with stray requests as noise
    task automatic fill_traffic(input int n_items, input int nack_pct);
        int counted;
        int span;
        int half_eff;
        counted = 0;
        half_eff = (half_ticks == '0) ? 1 : int'(half_ticks);
        while (counted < n_items)
        begin
            queue_item(1'b1, 1'($urandom_range(0, 1)), pick_byte(), 1'($urandom_range(0, 1)));
            counted++;
            span = 60 * half_eff + $urandom_range(0, 24);
            for (int k = 0; k < span && counted < n_items; k++)
            begin
                if ($urandom_range(0, 49) == 0)
                begin
                    queue_item(1'b1, 1'($urandom_range(0, 1)), pick_byte(),
                               1'($urandom_range(0, 1)));
                end
                else
                begin
                    queue_item(1'b0, 1'($urandom_range(0, 1)), pick_byte(),
                               1'($urandom_range(0, 99) < nack_pct));
                    counted++;
                end
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || in_valid || expected_lines.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input i2cdw_pkg::cfg_idx_t idx,
                             input logic [i2cdw_pkg::CFG_W-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            i2cdw_pkg::CFG_HALF_PERIOD: half_ticks = data[i2cdw_pkg::HALF_W-1:0];
            i2cdw_pkg::CFG_ACK_TIMEOUT: ack_limit = data[i2cdw_pkg::TIMEOUT_W-1:0];
            default:                    dev_addr = data[i2cdw_pkg::ADDR_W-1:0];
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_setting(input logic [i2cdw_pkg::CFG_W-1:0] half,
                                 input logic [i2cdw_pkg::CFG_W-1:0] tmo,
                                 input logic [i2cdw_pkg::CFG_W-1:0] addr);
        wait_drained();
        write_reg(i2cdw_pkg::CFG_HALF_PERIOD, half);
        write_reg(i2cdw_pkg::CFG_ACK_TIMEOUT, tmo);
        write_reg(i2cdw_pkg::CFG_DEV_ADDR, addr);
        settings_used++;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        settings_used = 1;

        // idle ticks, a data write with all ones, a command request while busy
        queue_item(1'b0, 1'b0, 8'h00, 1'b0);
        queue_item(1'b0, 1'b1, 8'hFF, 1'b1);
        queue_item(1'b1, 1'b1, 8'hFF, 1'b0);
        queue_item(1'b1, 1'b0, 8'h00, 1'b1);
        for (int k = 0; k < 20; k++)
            queue_item(1'b0, 1'b0, 8'h00, 1'b0);

        fill_traffic(220, 25);

        // widest timeout, written with upper bits set
        apply_setting(16'd1, 16'hFFFF, {8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))});
        fill_traffic(200, 40);

        // zero half period and zero timeout: any failing poll aborts
        apply_setting(16'd0, 16'd0, 16'h00FF);
        fill_traffic(150, 50);

        // short timeout with mostly missing acknowledges
        apply_setting(16'd3, 16'd3, 16'h0000);
        fill_traffic(200, 85);

        // longest half period, left before the hold runs out
        apply_setting(16'hFFFF, 16'd1, 16'h0078);
        fill_traffic(30, 20);

        apply_setting(16'd1, 16'd1, 16'($urandom_range(0, 255)));
        allow_idling = 1'b0;
        fill_traffic(200, 30);

        wait_drained();
        repeat (5) @(posedge clk);

        $display("checked %0d result transactions over %0d register settings",
                 lines_checked, settings_used);
        $display("%0d display writes framed, %0d aborted on missing ack, %0d requests refused",
                 writes_framed, writes_aborted, requests_refused);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
